// ===== design/bsag_pkg.sv =====
// shared constants and register indexes for the broadcast strided address generator
package bsag_pkg;

	localparam int SLOT_BITS       = 16;
	localparam int NUM_SLOTS       = 4;
	localparam int CFG_BITS        = SLOT_BITS * NUM_SLOTS;
	localparam int IDX_BITS        = 32;
	localparam int OFF_BITS        = 34;
	localparam int RANK_BITS       = 3;
	localparam int RANKS_BITS      = 3 * RANK_BITS;
	localparam int REG_IDX_BITS    = 3;
	localparam int STEP_BITS       = 4;
	localparam int DEF_MAX_DIMS    = 4;
	localparam int DEF_EXTENT_BITS = 16;

	localparam logic [RANKS_BITS-1:0] RANKS_RESET = RANKS_BITS'(73);

	localparam logic [REG_IDX_BITS-1:0] REG_RANKS         = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_OUT_EXTENTS   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_OUT_STRIDES   = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_IN_EXTENTS    = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_IN_STRIDES    = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_OTHER_EXTENTS = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_OTHER_STRIDES = 3'd6;

endpackage

// ===== design/bsag_in_if.sv =====
// input stream channel carrying the linear element index
interface bsag_in_if;
	logic                           valid;
	logic                           ready;
	logic [bsag_pkg::IDX_BITS-1:0]  element_index;

	modport source (output valid, output element_index, input ready);
	modport sink (input valid, input element_index, output ready);
endinterface

// ===== design/bsag_out_if.sv =====
// output stream channel carrying the three element offsets
interface bsag_out_if;
	logic                           valid;
	logic                           ready;
	logic [bsag_pkg::OFF_BITS-1:0]  out_elem_off;
	logic [bsag_pkg::OFF_BITS-1:0]  first_elem_off;
	logic [bsag_pkg::OFF_BITS-1:0]  second_elem_off;

	modport source (output valid, output out_elem_off, output first_elem_off,
		output second_elem_off, input ready);
	modport sink (input valid, input out_elem_off, input first_elem_off,
		input second_elem_off, output ready);
endinterface

// ===== design/bsag_div_stage.sv =====
// one pipeline stage of a restoring divider, four quotient bits per stage
module bsag_div_stage #(
	parameter int EXTENT_BITS = bsag_pkg::DEF_EXTENT_BITS,
	parameter bit START       = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  logic [EXTENT_BITS-1:0]        rem_in,
	input  logic [bsag_pkg::IDX_BITS-1:0] num_in,
	input  logic [EXTENT_BITS-1:0]        divisor,
	output logic                          v_s,
	output logic [EXTENT_BITS-1:0]        rem_s,
	output logic [bsag_pkg::IDX_BITS-1:0] num_s
);

	logic [EXTENT_BITS-1:0]        rem_c;
	logic [bsag_pkg::IDX_BITS-1:0] num_c;
	logic [EXTENT_BITS:0]          trial;

	always_comb begin
		rem_c = START ? '0 : rem_in;
		num_c = num_in;
		trial = '0;
		for (int j = 0; j < bsag_pkg::STEP_BITS; j++) begin
			trial = {rem_c, num_c[bsag_pkg::IDX_BITS-1]};
			num_c = {num_c[bsag_pkg::IDX_BITS-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_c    = EXTENT_BITS'(trial - {1'b0, divisor});
				num_c[0] = 1'b1;
			end else begin
				rem_c = trial[EXTENT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= 1'b0;
		end else if (en) begin
			v_s <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_c;
			num_s <= num_c;
		end
	end

endmodule

// ===== design/broadcast_strided_address_generator_top.sv =====
// top level of the broadcast strided address generator
// Accepts one element index per cycle unless the output stalls, and returns the output, first
// operand and second operand element offsets in order, one beat per index. The pipeline is
// the pipelined restoring divider, which resolves four quotient bits per stage for each
// dimension, followed by one multiply stage and the output register, which also forms the
// sums. Stalls on the output back up stage by stage and bubbles are squeezed out. Registers
// must be written only while no beat is in flight; the block itself does not enforce this.
// A write takes effect for a beat accepted in the following cycle.
module broadcast_strided_address_generator_top #(
	parameter int MAX_DIMS    = bsag_pkg::DEF_MAX_DIMS,
	parameter int EXTENT_BITS = bsag_pkg::DEF_EXTENT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bsag_pkg::REG_IDX_BITS-1:0] cfg_idx,
	input  logic [bsag_pkg::CFG_BITS-1:0]     cfg_data,
	bsag_in_if.sink                           in_ch,
	bsag_out_if.source                        out_ch
);

	localparam int W      = EXTENT_BITS;
	localparam int SB     = bsag_pkg::SLOT_BITS;
	localparam int PW     = W + SB;
	localparam int DSTEPS = bsag_pkg::IDX_BITS / bsag_pkg::STEP_BITS;
	localparam int NS     = MAX_DIMS * DSTEPS;

	// configuration registers
	logic [bsag_pkg::RANKS_BITS-1:0] ranks_q;
	logic [bsag_pkg::CFG_BITS-1:0]   out_ext_q, out_str_q, in_ext_q, in_str_q;
	logic [bsag_pkg::CFG_BITS-1:0]   oth_ext_q, oth_str_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ranks_q   <= bsag_pkg::RANKS_RESET;
			out_ext_q <= '0;
			out_str_q <= '0;
			in_ext_q  <= '0;
			in_str_q  <= '0;
			oth_ext_q <= '0;
			oth_str_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				bsag_pkg::REG_RANKS:         ranks_q   <= cfg_data[bsag_pkg::RANKS_BITS-1:0];
				bsag_pkg::REG_OUT_EXTENTS:   out_ext_q <= cfg_data;
				bsag_pkg::REG_OUT_STRIDES:   out_str_q <= cfg_data;
				bsag_pkg::REG_IN_EXTENTS:    in_ext_q  <= cfg_data;
				bsag_pkg::REG_IN_STRIDES:    in_str_q  <= cfg_data;
				bsag_pkg::REG_OTHER_EXTENTS: oth_ext_q <= cfg_data;
				bsag_pkg::REG_OTHER_STRIDES: oth_str_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per dimension divisor and effective strides
	logic [W-1:0]  dvs_c [MAX_DIMS];
	logic [SB-1:0] os_c [MAX_DIMS];
	logic [SB-1:0] is_c [MAX_DIMS];
	logic [SB-1:0] ts_c [MAX_DIMS];
	logic [SB-1:0] os_q [MAX_DIMS];
	logic [SB-1:0] is_q [MAX_DIMS];
	logic [SB-1:0] ts_q [MAX_DIMS];

	function automatic int sat_rank(input logic [bsag_pkg::RANK_BITS-1:0] r);
		int v;
		v = int'(r);
		return (v > MAX_DIMS) ? MAX_DIMS : v;
	endfunction

	always_comb begin
		int nd, ri, rt, li, lt;
		logic [SB-1:0] ext, iex, tex;
		nd = sat_rank(ranks_q[2:0]);
		ri = sat_rank(ranks_q[5:3]);
		rt = sat_rank(ranks_q[8:6]);
		for (int d = 0; d < MAX_DIMS; d++) begin
			ext = out_ext_q[d*SB +: SB];
			li  = d + ri - nd;
			lt  = d + rt - nd;
			iex = in_ext_q[int'(2'(li))*SB +: SB];
			tex = oth_ext_q[int'(2'(lt))*SB +: SB];
			dvs_c[d] = (d < nd && ext[W-1:0] != '0) ? ext[W-1:0] : W'(1);
			os_c[d]  = out_str_q[d*SB +: SB];
			is_c[d]  = (d < nd && li >= 0 && iex[W-1:0] > W'(1)) ?
				in_str_q[int'(2'(li))*SB +: SB] : '0;
			ts_c[d]  = (d < nd && lt >= 0 && tex[W-1:0] > W'(1)) ?
				oth_str_q[int'(2'(lt))*SB +: SB] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				os_q[d]  <= '0;
				is_q[d]  <= '0;
				ts_q[d]  <= '0;
			end
		end else begin
			os_q  <= os_c;
			is_q  <= is_c;
			ts_q  <= ts_c;
		end
	end

	// divider pipeline, innermost dimension first
	logic [NS-1:0]                 dv_v_s;
	logic [NS-1:0]                 en;
	logic [W-1:0]                  dv_rem_s [NS];
	logic [bsag_pkg::IDX_BITS-1:0] dv_num_s [NS];
	logic [W-1:0]                  crd_s [NS][MAX_DIMS];
	logic                          en_pr, en_out;
	logic                          pr_v_s1;
	logic                          out_v_q;

	assign in_ch.ready = en[0];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int DIM = MAX_DIMS - 1 - k / DSTEPS;
		localparam bit START = (k % DSTEPS) == 0;

		if (k == NS - 1) begin : g_last
			assign en[k] = !dv_v_s[k] || en_pr;
		end else begin : g_mid
			assign en[k] = !dv_v_s[k] || en[k+1];
		end

		if (k == 0) begin : g_first
			bsag_div_stage #(.EXTENT_BITS(W), .START(1'b1)) u_div (
				.clk(clk), .arst_n(arst_n), .en(en[k]), .v_in(in_ch.valid),
				.rem_in('0), .num_in(in_ch.element_index), .divisor(dvs_c[DIM]),
				.v_s(dv_v_s[k]), .rem_s(dv_rem_s[k]), .num_s(dv_num_s[k])
			);
			always_ff @(posedge clk) begin
				if (en[k]) begin
					for (int d = 0; d < MAX_DIMS; d++) begin
						crd_s[k][d] <= '0;
					end
				end
			end
		end else begin : g_next
			bsag_div_stage #(.EXTENT_BITS(W), .START(START)) u_div (
				.clk(clk), .arst_n(arst_n), .en(en[k]), .v_in(dv_v_s[k-1]),
				.rem_in(dv_rem_s[k-1]), .num_in(dv_num_s[k-1]), .divisor(dvs_c[DIM]),
				.v_s(dv_v_s[k]), .rem_s(dv_rem_s[k]), .num_s(dv_num_s[k])
			);
			if (START) begin : g_capture
				always_ff @(posedge clk) begin
					if (en[k]) begin
						for (int d = 0; d < MAX_DIMS; d++) begin
							crd_s[k][d] <= (d == DIM + 1) ? dv_rem_s[k-1] : crd_s[k-1][d];
						end
					end
				end
			end else begin : g_carry
				always_ff @(posedge clk) begin
					if (en[k]) begin
						crd_s[k] <= crd_s[k-1];
					end
				end
			end
		end
	end

	// multiply stage
	logic [W-1:0]  crd_f [MAX_DIMS];
	logic [PW-1:0] po_s1 [MAX_DIMS];
	logic [PW-1:0] pi_s1 [MAX_DIMS];
	logic [PW-1:0] pt_s1 [MAX_DIMS];

	always_comb begin
		crd_f    = crd_s[NS-1];
		crd_f[0] = dv_rem_s[NS-1];
	end

	assign en_pr = !pr_v_s1 || en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_v_s1 <= 1'b0;
		end else if (en_pr) begin
			pr_v_s1 <= dv_v_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_pr) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				po_s1[d] <= PW'(crd_f[d]) * PW'(os_q[d]);
				pi_s1[d] <= PW'(crd_f[d]) * PW'(is_q[d]);
				pt_s1[d] <= PW'(crd_f[d]) * PW'(ts_q[d]);
			end
		end
	end

	// combinational sum and output register
	logic [bsag_pkg::OFF_BITS-1:0] so_c, si_c, st_c;
	logic [bsag_pkg::OFF_BITS-1:0] so_q, si_q, st_q;

	always_comb begin
		so_c = '0;
		si_c = '0;
		st_c = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			so_c = so_c + bsag_pkg::OFF_BITS'(po_s1[d]);
			si_c = si_c + bsag_pkg::OFF_BITS'(pi_s1[d]);
			st_c = st_c + bsag_pkg::OFF_BITS'(pt_s1[d]);
		end
	end

	assign en_out = !out_v_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= pr_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			so_q <= so_c;
			si_q <= si_c;
			st_q <= st_c;
		end
	end

	assign out_ch.valid           = out_v_q;
	assign out_ch.out_elem_off    = so_q;
	assign out_ch.first_elem_off  = si_q;
	assign out_ch.second_elem_off = st_q;

	// a full stalled pipeline never takes a new beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.ready && out_ch.valid && !out_ch.ready) |-> !((&dv_v_s) && pr_v_s1))
		else $error("beat accepted into a full stalled pipeline");

	// divisors are never zero
	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n) dvs_c[d] != '0)
			else $error("zero divisor for a dimension");
	end

endmodule
